>>> sv/sird_pkg.sv
`timescale 1ns / 1ps

package sird_pkg;

	localparam int SYM_W        = 8;
	localparam int DIGIT_W      = 6;
	localparam int RADIX_W      = 7;
	localparam int NUM_REGS     = 8;
	localparam int REG_W        = 64;
	localparam int ALPHA_BYTES  = 64;
	localparam int DIV_STEPS    = 4;

	localparam logic [SYM_W-1:0] MINUS_BYTE   = 8'h2D;
	localparam logic [SYM_W-1:0] PLUS_BYTE    = 8'h2B;
	localparam logic [SYM_W-1:0] LAST_CONTROL = 8'd31;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> sv/signed_integer_to_radix_digits.sv
`timescale 1ns / 1ps

// Writes a signed value out as a stream of byte symbols in the radix set by the
// alphabet held in eight 64-bit registers (APB, byte address 8*i, always ready).
// The radix is the count of alphabet bytes before the first zero byte.
// Input channel: value, valid/ready. Result channel: symbol, last, base_error,
// res_valid/res_ready; a negative value gives a minus first, digits follow
// most significant first, last marks the final word of a value.
// A bad alphabet gives one word with base_error set and symbol zero.
// Sequence per value: an alphabet check that steps through the bytes up to the
// terminator, then one division by the radix per digit in the divider
// (four quotient bits a cycle), then the minus, if any, and one word per digit.
// ready is high only between values.
// The output register holds a word until res_ready; a stalled receiver stalls
// the sequencer but a finished word never blocks acceptance of the next value.
// Reset clears the alphabet to zero and returns the sequencer to idle.
module signed_integer_to_radix_digits import sird_pkg::*; #(
	parameter int MAX_SYMBOLS = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [5:0]                    paddr,
	input  logic [REG_W-1:0]              pwdata,
	output logic [REG_W-1:0]              prdata,
	output logic                          pready,
	input  logic                          valid,
	output logic                          ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [SYM_W-1:0]              symbol,
	output logic                          last,
	output logic                          base_error
);

	localparam int SP_W = $clog2(VALUE_WIDTH + 1);
	localparam int AD_W = $clog2(VALUE_WIDTH);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_ERR, S_DIV_START, S_DIV_WAIT, S_SIGN, S_POP, S_SHOW
	} state_t;

	state_t                   state_q;
	logic [NUM_REGS*REG_W-1:0] alpha_q;
	logic [RADIX_W-1:0]       idx_q;
	logic [VALUE_WIDTH-1:0]   mag_q;
	logic                     neg_q;
	logic [SP_W-1:0]          sp_q;
	logic [DIGIT_W-1:0]       rd_q;
	logic                     res_valid_q;
	logic [SYM_W-1:0]         symbol_q;
	logic                     last_q;
	logic                     err_q;

	logic [DIGIT_W-1:0]       dig_mem [VALUE_WIDTH];

	logic                     in_acc;
	logic                     can_load;
	logic [DIGIT_W-1:0]       sel;
	logic [SYM_W-1:0]         cur;
	logic                     dup;
	logic                     bad_byte;
	logic [VALUE_WIDTH-1:0]   in_mag;
	logic                     push;
	logic                     pop;

	logic [VALUE_WIDTH-1:0]   quotient;
	logic [DIGIT_W-1:0]       remainder;
	div_stat_t                div_stat;

	// config port
	assign pready = 1'b1;
	assign prdata = alpha_q[{paddr[5:3], 6'b000000} +: REG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
		end else if (psel && penable && pwrite) begin
			alpha_q[{paddr[5:3], 6'b000000} +: REG_W] <= pwdata;
		end
	end

	assign ready    = (state_q == S_IDLE);
	assign in_acc   = valid && ready;
	assign can_load = !res_valid_q || res_ready;
	assign in_mag   = value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(~value) + VALUE_WIDTH'(1))
	                                       : VALUE_WIDTH'(value);

	// single byte read port, shared by the check and the symbol lookup
	assign sel = (state_q == S_SHOW) ? rd_q : idx_q[DIGIT_W-1:0];
	assign cur = alpha_q[{sel, 3'b000} +: SYM_W];

	always_comb begin
		dup = 1'b0;
		for (int b = 0; b < ALPHA_BYTES; b++) begin
			dup = dup || ((alpha_q[8*b +: SYM_W] == cur) && (RADIX_W'(b) < idx_q));
		end
	end

	assign bad_byte = (cur == MINUS_BYTE) || (cur == PLUS_BYTE) || (cur <= LAST_CONTROL);

	assign push = (state_q == S_DIV_WAIT) && div_stat.done;
	assign pop  = (state_q == S_POP);

	sird_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV_START),
		.dividend (mag_q),
		.divisor  (idx_q),
		.quotient (quotient),
		.remainder(remainder),
		.stat     (div_stat)
	);

	// digit stack, least significant pushed first
	always_ff @(posedge clk) begin
		if (push) begin
			dig_mem[sp_q[AD_W-1:0]] <= remainder;
		end
		if (pop) begin
			rd_q <= dig_mem[AD_W'(sp_q - SP_W'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			sp_q        <= '0;
			res_valid_q <= 1'b0;
			symbol_q    <= '0;
			last_q      <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						mag_q   <= in_mag;
						neg_q   <= value[VALUE_WIDTH-1];
						idx_q   <= '0;
						sp_q    <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					priority if ((idx_q == RADIX_W'(MAX_SYMBOLS)) || (cur == '0)) begin
						state_q <= (idx_q < RADIX_W'(2)) ? S_ERR : S_DIV_START;
					end else if (bad_byte || dup) begin
						state_q <= S_ERR;
					end else begin
						idx_q <= idx_q + RADIX_W'(1);
					end
				end
				S_ERR: begin
					if (can_load) begin
						res_valid_q <= 1'b1;
						symbol_q    <= '0;
						last_q      <= 1'b1;
						err_q       <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_stat.done) begin
						sp_q  <= sp_q + SP_W'(1);
						mag_q <= quotient;
						if (quotient == '0) begin
							state_q <= neg_q ? S_SIGN : S_POP;
						end else begin
							state_q <= S_DIV_START;
						end
					end
				end
				S_SIGN: begin
					if (can_load) begin
						res_valid_q <= 1'b1;
						symbol_q    <= MINUS_BYTE;
						last_q      <= 1'b0;
						err_q       <= 1'b0;
						state_q     <= S_POP;
					end
				end
				S_POP: begin
					sp_q    <= sp_q - SP_W'(1);
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (can_load) begin
						res_valid_q <= 1'b1;
						symbol_q    <= cur;
						last_q      <= (sp_q == '0);
						err_q       <= 1'b0;
						state_q     <= (sp_q == '0) ? S_IDLE : S_POP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign symbol     = symbol_q;
	assign last       = last_q;
	assign base_error = err_q;

	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> !div_stat.busy)
		else $error("divider running while idle");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && err_q |-> (symbol_q == '0) && last_q)
		else $error("error word malformed");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> sp_q != '0)
		else $error("digit stack underflow");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> sp_q < SP_W'(VALUE_WIDTH))
		else $error("digit stack overflow");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !ready)
		else $error("ready held after accept");

endmodule

>>> sv/sird_div.sv
`timescale 1ns / 1ps

module sird_div import sird_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [RADIX_W-1:0]     divisor,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [DIGIT_W-1:0]     remainder,
	output div_stat_t              stat
);

	localparam int DW   = ((VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int NCYC = DW / DIV_STEPS;
	localparam int CW   = $clog2(NCYC + 1);

	logic [DW-1:0]      acc_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [RADIX_W-1:0] dvs_q;
	logic [CW-1:0]      cnt_q;
	logic               done_q;

	logic [DW-1:0]      acc_d;
	logic [DIGIT_W-1:0] rem_d;

	// restoring division, several quotient bits a cycle; remainder stays below the divisor
	always_comb begin
		logic [RADIX_W-1:0] t;
		logic               qb;
		acc_d = acc_q;
		rem_d = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t  = {rem_d, acc_d[DW-1]};
			qb = (t >= dvs_q);
			rem_d = qb ? DIGIT_W'(t - dvs_q) : t[DIGIT_W-1:0];
			acc_d = {acc_d[DW-2:0], qb};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NCYC);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= DW'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
		end
	end

	assign quotient  = acc_q[VALUE_WIDTH-1:0];
	assign remainder = rem_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cnt_q) == CW'(1))
		else $error("divider done without a final step");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (dvs_q != '0) |-> {1'b0, rem_q} < dvs_q)
		else $error("remainder not below divisor");

endmodule

>>> dv/signed_integer_to_radix_digits_tb.sv
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_tb;
	import sird_pkg::*;

	localparam int HOLD_OFF    = 1500;
	localparam int STALL_LIMIT = 20000;
	localparam int BATCHES     = 16;
	localparam int BATCH_ITEMS = 27;

	typedef logic [SYM_W-1:0] alpha_t [ALPHA_BYTES];

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             err;
	} word_t;

	typedef enum int {FLAW_NONE, FLAW_SHORT, FLAW_DUP, FLAW_SIGN, FLAW_CTRL} flaw_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [5:0]           paddr = '0;
	logic [REG_W-1:0]     pwdata = '0;
	logic [REG_W-1:0]     prdata;
	logic                 pready;
	logic                 valid = 1'b0;
	logic                 ready;
	logic signed [31:0]   value = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic [SYM_W-1:0]     symbol;
	logic                 last;
	logic                 base_error;

	// own copy of the alphabet registers
	logic [REG_W-1:0]     symbol_regs [NUM_REGS];
	logic signed [31:0]   pending_values [$];
	word_t                due_words [$];
	word_t                got;

	int send_idle = 0;
	int recv_stall = 0;
	int hold_cycles = 0;
	bit in_took = 1'b0;
	int stall_cnt = 0;
	int errors = 0;
	int n_pushed = 0;
	int n_values = 0;
	int n_words = 0;
	int n_alpha = 0;
	int n_bad_alpha = 0;
	int radix_lo = ALPHA_BYTES;
	int radix_hi = 0;

	signed_integer_to_radix_digits i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.valid      (valid),
		.ready      (ready),
		.value      (value),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.symbol     (symbol),
		.last       (last),
		.base_error (base_error)
	);

	always #6 clk = ~clk;

	initial begin
		foreach (symbol_regs[i]) symbol_regs[i] = '0;
	end

	task automatic flag(input string msg);
		errors++;
		if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic logic [SYM_W-1:0] alpha_at(int k);
		return symbol_regs[k / 8][8 * (k % 8) +: 8];
	endfunction

	function automatic int radix_now();
		int n = 0;
		while (n < ALPHA_BYTES && alpha_at(n) != '0) n++;
		return n;
	endfunction

	function automatic bit alphabet_ok(int n);
		logic [SYM_W-1:0] c;
		if (n < 2) return 1'b0;
		for (int a = 0; a < n; a++) begin
			c = alpha_at(a);
			if (c == MINUS_BYTE || c == PLUS_BYTE || c <= LAST_CONTROL) return 1'b0;
			for (int b = a + 1; b < n; b++)
				if (alpha_at(b) == c) return 1'b0;
		end
		return 1'b1;
	endfunction

	// words due for one value into the queue: an error word, or any minus and digits most significant first
	task automatic predict_digits(input logic signed [31:0] v);
		longint unsigned rdx, rest, place, d;
		logic [32:0] mag;
		int n;
		n = radix_now();
		if (!alphabet_ok(n)) begin
			due_words.push_back('{sym: '0, last: 1'b1, err: 1'b1});
			return;
		end
		rdx = longint'(n);
		// 33-bit magnitude so the most negative value survives negation
		mag = v[31] ? 33'd0 - {v[31], v} : {1'b0, v};
		rest = longint'(mag);
		place = 1;
		while (place <= rest / rdx) place = place * rdx;
		if (v[31]) due_words.push_back('{sym: MINUS_BYTE, last: 1'b0, err: 1'b0});
		while (place != 0) begin
			d = rest / place;
			rest = rest % place;
			place = place / rdx;
			due_words.push_back('{sym: alpha_at(int'(d)), last: place == 0, err: 1'b0});
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (!valid || in_took) begin
			in_took = 1'b0;
			if (pending_values.size() != 0 && $urandom_range(99) >= send_idle) begin
				valid <= 1'b1;
				value <= pending_values.pop_front();
			end else begin
				valid <= 1'b0;
			end
		end
	end

	// receiver, with its own count of the long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (valid && ready) begin
			in_took = 1'b1;
			n_values++;
			predict_digits(value);
		end
		if (res_valid && res_ready) begin
			if (due_words.size() == 0) begin
				flag($sformatf("word with nothing due: symbol %02h last %0b err %0b",
					symbol, last, base_error));
			end else begin
				got = due_words.pop_front();
				n_words++;
				if (symbol !== got.sym || last !== got.last || base_error !== got.err)
					flag($sformatf("symbol %02h/%02h last %0b/%0b err %0b/%0b (exp/got)",
						got.sym, symbol, got.last, last, got.err, base_error));
			end
		end
		if ((valid && ready) || (res_valid && res_ready)) stall_cnt = 0;
		else stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_symbol_reg(input int idx, input logic [REG_W-1:0] data);
		logic [REG_W-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(8 * idx);
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		symbol_regs[idx] = data;
		if (rd !== data)
			flag($sformatf("register %0d read back %016h, wrote %016h", idx, rd, data));
	endtask

	task automatic apply_alphabet(input alpha_t a);
		logic [REG_W-1:0] packed_bytes;
		int n;
		for (int r = 0; r < NUM_REGS; r++) begin
			for (int k = 0; k < 8; k++) packed_bytes[8 * k +: 8] = a[8 * r + k];
			write_symbol_reg(r, packed_bytes);
		end
		n = radix_now();
		n_alpha++;
		if (!alphabet_ok(n)) begin
			n_bad_alpha++;
		end else begin
			if (n < radix_lo) radix_lo = n;
			if (n > radix_hi) radix_hi = n;
		end
	endtask

	function automatic alpha_t from_text(string s);
		alpha_t a;
		foreach (a[i]) a[i] = (i < s.len()) ? s[i] : 8'h00;
		return a;
	endfunction

	// distinct printable/high bytes, then a terminator and junk past it when shorter than full, then the chosen flaw
	function automatic alpha_t make_alphabet(int len, flaw_t flaw);
		alpha_t a;
		bit used [256];
		int c, p, n;
		if (flaw == FLAW_SHORT) len = $urandom_range(1);
		n = 0;
		while (n < len) begin
			c = $urandom_range(255, 32);
			if (!used[c] && c != MINUS_BYTE && c != PLUS_BYTE) begin
				used[c] = 1'b1;
				a[n] = 8'(c);
				n++;
			end
		end
		for (int i = len; i < ALPHA_BYTES; i++) a[i] = 8'($urandom_range(255));
		if (len < ALPHA_BYTES) a[len] = 8'h00;
		if (len >= 2) begin
			p = $urandom_range(len - 1, 1);
			case (flaw)
				FLAW_DUP:  a[p] = a[$urandom_range(p - 1, 0)];
				FLAW_SIGN: a[$urandom_range(len - 1, 0)] = $urandom_range(1) ? PLUS_BYTE : MINUS_BYTE;
				FLAW_CTRL: a[$urandom_range(len - 1, 0)] = 8'($urandom_range(31, 1));
				default: ;
			endcase
		end
		return a;
	endfunction

	function automatic logic signed [31:0] rand_value();
		longint unsigned p;
		longint lv;
		int r;
		logic [31:0] v;
		r = radix_now();
		if (r < 2) r = 10;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = 32'(int'($urandom_range(600)) - 300);
			6: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h7fff_ffff;
					2: v = 32'h0;
					default: v = 32'hffff_ffff;
				endcase
			end
			7, 8: begin
				// around a power of the radix, where the digit count steps
				p = 1;
				repeat ($urandom_range(31))
					if (p * r <= 64'h8000_0000) p = p * r;
				lv = longint'(p) - longint'($urandom_range(1));
				if ($urandom_range(1)) lv = -lv;
				if (lv > 64'sd2147483647) lv = 64'sd2147483647;
				v = lv[31:0];
			end
			default: begin
				v = 32'd1 << $urandom_range(31);
				if ($urandom_range(1)) v = ~v;
			end
		endcase
		return v;
	endfunction

	task automatic push_value(input logic signed [31:0] v);
		pending_values.push_back(v);
		n_pushed++;
	endtask

	// wait until every value is taken and every word has come back
	task automatic settle();
		while (n_values != n_pushed || due_words.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle = send_pct;
		recv_stall = recv_pct;
	endtask

	initial begin
		alpha_t wide;
		alpha_t bad [5];
		int len;
		flaw_t flaw;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(0, 0);
		// all-zero alphabet straight out of reset
		push_value(32'sd5);
		settle();

		apply_alphabet(from_text("0123456789"));
		push_value(32'sd0);
		push_value(32'sd1);
		push_value(-32'sd1);
		push_value(32'sd9);
		push_value(32'sd10);
		push_value(-32'sd10);
		push_value(32'h7fff_ffff);
		push_value(32'h8000_0000);
		settle();

		apply_alphabet(from_text("01"));
		push_value(32'h8000_0000);
		push_value(32'h7fff_ffff);
		push_value(32'sd0);
		push_value(-32'sd1);
		settle();

		// no terminator: radix 64, high bytes included
		foreach (wide[k]) wide[k] = (k < 8) ? 8'(32 + k) : 8'(120 + k);
		apply_alphabet(wide);
		push_value(32'h8000_0000);
		push_value(32'h7fff_ffff);
		push_value(32'sd63);
		push_value(32'sd64);
		push_value(-32'sd64);
		settle();

		bad[0] = from_text("A");
		bad[1] = from_text("abcda");
		bad[2] = from_text("01+");
		bad[3] = from_text("-01");
		bad[4] = from_text("0x1");
		bad[4][1] = LAST_CONTROL;
		foreach (bad[i]) begin
			apply_alphabet(bad[i]);
			push_value(-32'sd123);
			settle();
		end

		for (int b = 0; b < BATCHES; b++) begin
			case (b % 4)
				0: set_idling(0, 0);
				1: set_idling(87, 0);
				2: set_idling(0, 87);
				default: set_idling(29, 29);
			endcase
			flaw = FLAW_NONE;
			if (b % 5 == 1) flaw = flaw_t'($urandom_range(FLAW_CTRL, FLAW_SHORT));
			if (b == 8) len = 2;
			else if (b == 12) len = ALPHA_BYTES;
			else if ($urandom_range(1)) len = $urandom_range(16, 2);
			else len = $urandom_range(ALPHA_BYTES, 2);
			apply_alphabet(make_alphabet(len, flaw));
			if (b == 4) begin
				// long receiver hold-off while the sender keeps offering
				@(posedge clk);
				hold_cycles = HOLD_OFF;
			end
			repeat (BATCH_ITEMS) push_value(rand_value());
			settle();
		end

		repeat (64) @(negedge clk);
		$display("Wrote out %0d values under %0d alphabets (%0d invalid, radix %0d to %0d).",
			n_values, n_alpha, n_bad_alpha, radix_lo, radix_hi);
		$display("Checked %0d words, %0d mismatches.", n_words, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
